@@ hdl/gradient_structure_tensor_unit_assert.svh @@
// assertion macros used by the gradient structure tensor checker
`ifndef GRADIENT_STRUCTURE_TENSOR_UNIT_ASSERT_SVH
`define GRADIENT_STRUCTURE_TENSOR_UNIT_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define GST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define GST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after any cycle with reset asserted
`define GST_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gst_pkg.sv @@
// shared constants and types of the gradient structure tensor unit
package gst_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_MAX_STEP   = 8;

  localparam int PIX_W  = 16;
  localparam int DIFF_W = PIX_W + 1;
  localparam int SQ_W   = 32;
  localparam int XY_W   = 33;

  localparam int CFG_IW      = 2;
  localparam int CFG_DW      = 13;
  localparam int CFGW_WIDTH  = 11;
  localparam int CFGW_HEIGHT = 13;
  localparam int CFGW_STEP   = 4;

  localparam int RST_IMAGE_WIDTH   = 1024;
  localparam int RST_IMAGE_HEIGHT  = 4096;
  localparam int RST_GRADIENT_STEP = 1;

  typedef enum logic [CFG_IW-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_GRADIENT_STEP = 2'd2
  } gst_reg_t;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic               avail;
    logic [FIFO_CW-1:0] level;
  } gst_qstat_t;

endpackage

@@ hdl/gst_rowmem.sv @@
// row store: one bank per ring row, each with one write and two read ports
module gst_rowmem import gst_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int RING      = 2 * DEF_MAX_STEP + 1,
  localparam int XW       = $clog2(MAX_WIDTH),
  localparam int RW       = $clog2(RING)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [RW-1:0]    wr_bank,
  input  logic [XW-1:0]    wr_col,
  input  logic [PIX_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [RW-1:0]    rd_bank_c,
  input  logic [RW-1:0]    rd_bank_a,
  input  logic [XW-1:0]    rd_col_e,
  input  logic [XW-1:0]    rd_col_w,
  input  logic [XW-1:0]    rd_col_a,
  output logic [PIX_W-1:0] rd_east,
  output logic [PIX_W-1:0] rd_west,
  output logic [PIX_W-1:0] rd_above
);

  logic [PIX_W-1:0] qa_all [RING];
  logic [PIX_W-1:0] qb_all [RING];
  logic [RING-1:0]  selc_r;
  logic [RING-1:0]  sela_r;

  for (genvar b = 0; b < RING; b++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] qa_r;
    logic [PIX_W-1:0] qb_r;
    logic [XW-1:0]    addr_a;

    // port a serves east for the centre row and the sample above otherwise
    assign addr_a = (rd_bank_c == RW'(b)) ? rd_col_e : rd_col_a;

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == RW'(b))) begin
        mem[wr_col] <= wr_data;
      end
      if (rd_en) begin
        qa_r <= mem[addr_a];
        qb_r <= mem[rd_col_w];
      end
    end

    assign qa_all[b] = qa_r;
    assign qb_all[b] = qb_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      for (int i = 0; i < RING; i++) begin
        selc_r[i] <= (rd_bank_c == RW'(i));
        sela_r[i] <= (rd_bank_a == RW'(i));
      end
    end
  end

  always_comb begin
    rd_east  = '0;
    rd_west  = '0;
    rd_above = '0;
    for (int i = 0; i < RING; i++) begin
      rd_east  = rd_east  | (qa_all[i] & {PIX_W{selc_r[i]}});
      rd_west  = rd_west  | (qb_all[i] & {PIX_W{selc_r[i]}});
      rd_above = rd_above | (qa_all[i] & {PIX_W{sela_r[i]}});
    end
  end

endmodule

@@ hdl/gst_front.sv @@
// front end: configuration, raster position, border test and row store access
module gst_front import gst_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_STEP   = DEF_MAX_STEP,
  localparam int XW        = $clog2(MAX_WIDTH),
  localparam int YW        = $clog2(MAX_HEIGHT),
  localparam int IW        = XW + YW + 4 * PIX_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  in_pixel_value,
  input  logic              in_frame_start,
  input  gst_qstat_t        q_stat,
  output logic              push,
  output logic [IW-1:0]     push_data
);

  localparam int RING  = 2 * MAX_STEP + 1;
  localparam int RW    = $clog2(RING);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int SW    = $clog2(MAX_STEP + 1);
  localparam int CXW   = ((WW > SW) ? WW : SW) + 1;
  localparam int CYW   = ((HW > SW) ? HW : SW) + 1;
  localparam int RST_W = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
  localparam int RST_H = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;

  logic [WW-1:0] w_r;
  logic [HW-1:0] h_r;
  logic [SW-1:0] s_r;
  logic [WW-1:0] cfg_w;
  logic [HW-1:0] cfg_h;
  logic [SW-1:0] cfg_s;

  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic [RW-1:0] ring_r, ring_nxt;

  logic          accept;
  logic [XW-1:0] x_cur;
  logic [YW-1:0] y_cur;
  logic [RW-1:0] ring_cur;
  logic [CXW-1:0] xe, se_x, we;
  logic [CYW-1:0] ye, se_y, he;
  logic          hit;
  logic          x_last;
  logic          y_last;

  logic [RW:0]   bank_c_sum, bank_a_sum;
  logic [RW-1:0] bank_c, bank_a;
  logic [XW-1:0] col_e, col_w;

  logic             s1_hit_r;
  logic [XW-1:0]    s1_x_r;
  logic [YW-1:0]    s1_cy_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [PIX_W-1:0] east, west, above;

  // register values are clamped into their usable range when written
  always_comb begin
    if (cfg_wdata[CFGW_WIDTH-1:0] == '0) begin
      cfg_w = WW'(1);
    end else if (32'(cfg_wdata[CFGW_WIDTH-1:0]) > 32'(MAX_WIDTH)) begin
      cfg_w = WW'(MAX_WIDTH);
    end else begin
      cfg_w = WW'(cfg_wdata[CFGW_WIDTH-1:0]);
    end
    if (cfg_wdata[CFGW_HEIGHT-1:0] == '0) begin
      cfg_h = HW'(1);
    end else if (32'(cfg_wdata[CFGW_HEIGHT-1:0]) > 32'(MAX_HEIGHT)) begin
      cfg_h = HW'(MAX_HEIGHT);
    end else begin
      cfg_h = HW'(cfg_wdata[CFGW_HEIGHT-1:0]);
    end
    if (cfg_wdata[CFGW_STEP-1:0] == '0) begin
      cfg_s = SW'(1);
    end else if (32'(cfg_wdata[CFGW_STEP-1:0]) > 32'(MAX_STEP)) begin
      cfg_s = SW'(MAX_STEP);
    end else begin
      cfg_s = SW'(cfg_wdata[CFGW_STEP-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WW'(RST_W);
      h_r <= HW'(RST_H);
      s_r <= SW'(RST_GRADIENT_STEP);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   w_r <= cfg_w;
        REG_IMAGE_HEIGHT:  h_r <= cfg_h;
        REG_GRADIENT_STEP: s_r <= cfg_s;
        default: ;
      endcase
    end
  end

  // room for the item in flight plus one more
  assign in_stall = ((FIFO_CW + 1)'(q_stat.level) + (FIFO_CW + 1)'(s1_hit_r))
                    >= (FIFO_CW + 1)'(FIFO_DEPTH);
  assign accept = in_valid && !in_stall;

  assign x_cur    = in_frame_start ? '0 : col_r;
  assign y_cur    = in_frame_start ? '0 : row_r;
  assign ring_cur = in_frame_start ? '0 : ring_r;

  assign xe   = CXW'(x_cur);
  assign se_x = CXW'(s_r);
  assign we   = CXW'(w_r);
  assign ye   = CYW'(y_cur);
  assign se_y = CYW'(s_r);
  assign he   = CYW'(h_r);

  // this pixel is the lower neighbour of the centre one step above
  assign hit    = (ye >= (se_y << 1)) && (xe >= se_x) && ((xe + se_x) < we);
  assign x_last = (xe + CXW'(1)) >= we;
  assign y_last = (ye + CYW'(1)) >= he;

  always_comb begin
    col_nxt  = XW'(xe + CXW'(1));
    row_nxt  = y_cur;
    ring_nxt = ring_cur;
    if (x_last) begin
      col_nxt = '0;
      if (y_last) begin
        row_nxt  = '0;
        ring_nxt = '0;
      end else begin
        row_nxt  = YW'(ye + CYW'(1));
        ring_nxt = (ring_cur == RW'(RING - 1)) ? '0 : ring_cur + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ring_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ring_r <= ring_nxt;
    end
  end

  // ring rows of the centre and of the sample above, modulo the ring size
  assign bank_c_sum = {1'b0, ring_cur} + (RW + 1)'(RING) - (RW + 1)'(s_r);
  assign bank_a_sum = {1'b0, ring_cur} + (RW + 1)'(RING) - ((RW + 1)'(s_r) << 1);
  assign bank_c = (bank_c_sum >= (RW + 1)'(RING)) ? RW'(bank_c_sum - (RW + 1)'(RING))
                                                  : RW'(bank_c_sum);
  assign bank_a = (bank_a_sum >= (RW + 1)'(RING)) ? RW'(bank_a_sum - (RW + 1)'(RING))
                                                  : RW'(bank_a_sum);
  assign col_e  = XW'(xe + se_x);
  assign col_w  = XW'(xe - se_x);

  gst_rowmem #(
    .MAX_WIDTH (MAX_WIDTH),
    .RING      (RING)
  ) u_rowmem (
    .clk       (clk),
    .wr_en     (accept),
    .wr_bank   (ring_cur),
    .wr_col    (x_cur),
    .wr_data   (in_pixel_value),
    .rd_en     (accept && hit),
    .rd_bank_c (bank_c),
    .rd_bank_a (bank_a),
    .rd_col_e  (col_e),
    .rd_col_w  (col_w),
    .rd_col_a  (x_cur),
    .rd_east   (east),
    .rd_west   (west),
    .rd_above  (above)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_hit_r <= 1'b0;
    end else begin
      s1_hit_r <= accept && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r   <= x_cur;
      s1_cy_r  <= YW'(ye - se_y);
      s1_pix_r <= in_pixel_value;
    end
  end

  assign push      = s1_hit_r;
  assign push_data = {s1_x_r, s1_cy_r, east, west, above, s1_pix_r};

endmodule

@@ hdl/gst_fifo.sv @@
// short queue between the front end and the arithmetic back end
module gst_fifo import gst_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output gst_qstat_t    stat
);

  logic [DW-1:0]      mem_r [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wp_r, wp_nxt;
  logic [FIFO_PW-1:0] rp_r, rp_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  assign wp_nxt = (wp_r == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wp_r + FIFO_PW'(1);
  assign rp_nxt = (rp_r == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rp_r + FIFO_PW'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FIFO_CW'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_nxt;
      end
      if (pop) begin
        rp_r <= rp_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  assign dout       = mem_r[rp_r];
  assign stat.avail = (cnt_r != '0);
  assign stat.level = cnt_r;

endmodule

@@ hdl/gst_back.sv @@
// back end: differences, then the three tensor products into the output register
module gst_back import gst_pkg::*; #(
  parameter int XW = 10,
  parameter int YW = 12,
  localparam int IW = XW + YW + 4 * PIX_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_avail,
  input  logic [IW-1:0]          q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [XW-1:0]          out_center_x,
  output logic [YW-1:0]          out_center_y,
  output logic [SQ_W-1:0]        out_grad_xx,
  output logic signed [XY_W-1:0] out_grad_xy,
  output logic [SQ_W-1:0]        out_grad_yy
);

  logic [XW-1:0]    q_x;
  logic [YW-1:0]    q_cy;
  logic [PIX_W-1:0] q_east, q_west, q_above, q_below;

  logic                     a_valid_r;
  logic [XW-1:0]            a_x_r;
  logic [YW-1:0]            a_cy_r;
  logic signed [DIFF_W-1:0] a_ix_r, a_iy_r;
  logic signed [DIFF_W-1:0] ix, iy;

  logic signed [2*DIFF_W-1:0] pxx, pxy, pyy;

  logic                   out_valid_r;
  logic [XW-1:0]          out_x_r;
  logic [YW-1:0]          out_y_r;
  logic [SQ_W-1:0]        out_xx_r;
  logic signed [XY_W-1:0] out_xy_r;
  logic [SQ_W-1:0]        out_yy_r;

  logic b_load;
  logic a_load;

  assign {q_x, q_cy, q_east, q_west, q_above, q_below} = q_data;

  assign ix = signed'({1'b0, q_east})  - signed'({1'b0, q_west});
  assign iy = signed'({1'b0, q_below}) - signed'({1'b0, q_above});

  assign b_load = !out_valid_r || !out_stall;
  assign a_load = !a_valid_r || b_load;
  assign q_pop  = a_load && q_avail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_r <= q_avail;
      end
      if (b_load) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_x_r  <= q_x;
      a_cy_r <= q_cy;
      a_ix_r <= ix;
      a_iy_r <= iy;
    end
  end

  assign pxx = a_ix_r * a_ix_r;
  assign pxy = a_ix_r * a_iy_r;
  assign pyy = a_iy_r * a_iy_r;

  always_ff @(posedge clk) begin
    if (b_load && a_valid_r) begin
      out_x_r  <= a_x_r;
      out_y_r  <= a_cy_r;
      out_xx_r <= pxx[SQ_W-1:0];
      out_xy_r <= pxy[XY_W-1:0];
      out_yy_r <= pyy[SQ_W-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_center_x = out_x_r;
  assign out_center_y = out_y_r;
  assign out_grad_xx  = out_xx_r;
  assign out_grad_xy  = out_xy_r;
  assign out_grad_yy  = out_yy_r;

endmodule

@@ hdl/gradient_structure_tensor_unit.sv @@
// path: lower pixel, row store read, result queue, difference register, output register
// throughput: one pixel per clock; the four-entry result queue holds in_stall low until
// out_stall backs it up, and the per-row banks of the row store serve all reads at once
// border pixels only update the row store and give no result
// reset: synchronous, clears position and all valid state and loads the register defaults;
// the row store is not cleared and needs no clearing pass
module gradient_structure_tensor_unit import gst_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_STEP   = DEF_MAX_STEP,
  localparam int XW        = $clog2(MAX_WIDTH),
  localparam int YW        = $clog2(MAX_HEIGHT)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [PIX_W-1:0]       in_pixel_value,
  input  logic                   in_frame_start,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [XW-1:0]          out_center_x,
  output logic [YW-1:0]          out_center_y,
  output logic [SQ_W-1:0]        out_grad_xx,
  output logic signed [XY_W-1:0] out_grad_xy,
  output logic [SQ_W-1:0]        out_grad_yy,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IW-1:0]      cfg_index,
  input  logic [CFG_DW-1:0]      cfg_wdata
);

  localparam int IW = XW + YW + 4 * PIX_W;

  logic          push;
  logic [IW-1:0] push_data;
  logic          pop;
  logic [IW-1:0] q_data;
  gst_qstat_t    q_stat;

  assign cfg_ready = 1'b1;

  gst_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_STEP   (MAX_STEP)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .in_frame_start (in_frame_start),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  gst_fifo #(
    .DW (IW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_data),
    .pop   (pop),
    .dout  (q_data),
    .stat  (q_stat)
  );

  gst_back #(
    .XW (XW),
    .YW (YW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_avail      (q_stat.avail),
    .q_data       (q_data),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_center_x (out_center_x),
    .out_center_y (out_center_y),
    .out_grad_xx  (out_grad_xx),
    .out_grad_xy  (out_grad_xy),
    .out_grad_yy  (out_grad_yy)
  );

endmodule

@@ hdl/gst_checker.sv @@
// port-level checks of the gradient structure tensor unit and their binding
`include "gradient_structure_tensor_unit_assert.svh"

module gst_checker import gst_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int XW        = $clog2(MAX_WIDTH),
  localparam int YW        = $clog2(MAX_HEIGHT)
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [XW-1:0]          out_center_x,
  input logic [YW-1:0]          out_center_y,
  input logic [SQ_W-1:0]        out_grad_xx,
  input logic signed [XY_W-1:0] out_grad_xy,
  input logic [SQ_W-1:0]        out_grad_yy
);

  logic [XW+YW+2*SQ_W+XY_W-1:0] out_bus;
  logic                         xx_zero;
  logic                         yy_zero;
  logic                         xy_zero;

  assign out_bus = {out_center_x, out_center_y, out_grad_xx, out_grad_xy, out_grad_yy};
  assign xx_zero = (out_grad_xx == '0);
  assign yy_zero = (out_grad_yy == '0);
  assign xy_zero = (out_grad_xy == '0);

  `GST_ASSERT_RST(a_no_result_after_reset, !out_valid, "result valid right after reset")

  `GST_ASSERT_NEXT(a_valid_holds, out_valid && out_stall, out_valid, "stalled result dropped")

  `GST_ASSERT_NEXT(a_payload_holds, out_valid && out_stall, $stable(out_bus), "stalled result changed")

  // a zero difference in either direction zeroes the cross product
  `GST_ASSERT_NOW(a_xx_zero_xy, out_valid && xx_zero, xy_zero, "xy nonzero with zero xx")

  `GST_ASSERT_NOW(a_yy_zero_xy, out_valid && yy_zero, xy_zero, "xy nonzero with zero yy")

endmodule

bind gradient_structure_tensor_unit gst_checker #(
  .MAX_WIDTH  (MAX_WIDTH),
  .MAX_HEIGHT (MAX_HEIGHT)
) u_gst_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_center_x (out_center_x),
  .out_center_y (out_center_y),
  .out_grad_xx  (out_grad_xx),
  .out_grad_xy  (out_grad_xy),
  .out_grad_yy  (out_grad_yy)
);
